// ===== src/rsn_pkg.sv =====
// Shared types and constants for the ray and sphere nearest-hit block.
// Holds the item and result words, the controller command and status words
// and the register codes. No dependencies.
`default_nettype none

package rsn_pkg;

  typedef struct packed {
    logic               kind;
    logic [9:0]         pixel_x;
    logic [8:0]         pixel_y;
    logic [1:0]         sphere_slot;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        radius;
  } rsn_item_t;

  typedef struct packed {
    logic        hit;
    logic [1:0]  sphere_index;
    logic [30:0] distance;
    logic [9:0]  out_pixel_x;
    logic [8:0]  out_pixel_y;
  } rsn_result_t;

  // datapath operations
  localparam logic [3:0] OP_IDLE      = 4'd0;
  localparam logic [3:0] OP_ACCEPT    = 4'd1;
  localparam logic [3:0] OP_DIV_PIX   = 4'd2;
  localparam logic [3:0] OP_STORE_PIX = 4'd3;
  localparam logic [3:0] OP_MAG       = 4'd4;
  localparam logic [3:0] OP_NORM      = 4'd5;
  localparam logic [3:0] OP_MUL       = 4'd6;
  localparam logic [3:0] OP_ACC       = 4'd7;
  localparam logic [3:0] OP_SQRT      = 4'd8;
  localparam logic [3:0] OP_STORE_M   = 4'd9;
  localparam logic [3:0] OP_DIV_DIR   = 4'd10;
  localparam logic [3:0] OP_STORE_DIR = 4'd11;
  localparam logic [3:0] OP_LOAD_W    = 4'd12;
  localparam logic [3:0] OP_FORM_B    = 4'd13;
  localparam logic [3:0] OP_HIT       = 4'd14;
  localparam logic [3:0] OP_RESULT    = 4'd15;

  // multiplier operand pairs
  localparam logic [2:0] MS_MAG = 3'd0;
  localparam logic [2:0] MS_DW  = 3'd1;
  localparam logic [2:0] MS_WW  = 3'd2;
  localparam logic [2:0] MS_RR  = 3'd3;
  localparam logic [2:0] MS_BB  = 3'd4;

  // accumulator targets
  localparam logic TGT_C = 1'b0;
  localparam logic TGT_B = 1'b1;

  // configuration register indexes
  localparam logic [1:0] REG_EYE_X   = 2'd0;
  localparam logic [1:0] REG_EYE_Y   = 2'd1;
  localparam logic [1:0] REG_EYE_Z   = 2'd2;
  localparam logic [1:0] REG_DIVISOR = 2'd3;

  localparam logic signed [31:0] EYE_X_RST   = 32'sd32768;
  localparam logic signed [31:0] EYE_Y_RST   = 32'sd32768;
  localparam logic signed [31:0] EYE_Z_RST   = -32'sd65536;
  localparam logic [11:0]        DIVISOR_RST = 12'd480;

  localparam logic [5:0] DIV_STEPS  = 6'd32;
  localparam logic [5:0] SQRT_STEPS = 6'd36;

  localparam int SLOT_CMD_W = 6;

  typedef struct packed {
    logic [3:0]            op;
    logic [2:0]            msel;
    logic [1:0]            idx;
    logic                  clr;
    logic                  neg;
    logic                  tgt;
    logic [SLOT_CMD_W-1:0] slot;
  } rsn_cmd_t;

  typedef struct packed {
    logic cast_ok;
    logic div_done;
    logic sqrt_done;
    logic mx_zero;
    logic norm_ok;
    logic disc_pos;
    logic out_free;
  } rsn_status_t;

endpackage

`default_nettype wire

// ===== src/ray_sphere_nearest_hit.sv =====
// Ray and sphere nearest-hit block, top level: controller plus datapath.
// A load word leaves the block ready again in the next cycle. A cast word runs
// two pixel divisions, up to 30 normalization shifts, a root and three
// divisions for the unit ray, then per sphere operand loads and
// multiply-accumulate on the one shared multiplier plus a root when the
// discriminant is positive. A cast whose ray has zero length goes straight to
// the result after the normalization check, with no hit.
// A finished result waits in the output register while the next word is taken.
// The sphere table is cleared by reset. Uses rsn_pkg, rsn_ctrl, rsn_datapath.
`default_nettype none

module ray_sphere_nearest_hit #(
  parameter int NUM_SPHERES   = 4,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rsn_pkg::rsn_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rsn_pkg::rsn_result_t result
);
  import rsn_pkg::*;

  rsn_cmd_t    cmd;
  rsn_status_t status;

  rsn_ctrl #(
    .NUM_SPHERES (NUM_SPHERES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  rsn_datapath #(
    .NUM_SPHERES   (NUM_SPHERES),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_ready (result_ready),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== src/rsn_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, 32-bit quotient.
// The upper half of the dividend must be below the divisor. Uses rsn_pkg.
`default_nettype none

module rsn_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic        done,
  output logic [31:0] quo
);
  import rsn_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] nlo;
  logic [31:0] dvs;
  logic [32:0] rem2;
  logic        ge;
  logic [32:0] diff;

  assign rem2 = {rem, nlo[31]};
  assign ge   = rem2 >= {1'b0, dvs};
  assign diff = rem2 - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= DIV_STEPS;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num[63:32];
      nlo <= num[31:0];
      dvs <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= ge ? diff[31:0] : rem2[31:0];
      nlo <= {nlo[30:0], 1'b0};
      quo <= {quo[30:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== src/rsn_sqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Gives floor(sqrt) of a 72-bit unsigned value as a 36-bit root. Uses rsn_pkg.
`default_nettype none

module rsn_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [71:0] radicand,
  output logic        done,
  output logic [35:0] root
);
  import rsn_pkg::*;

  logic        busy;
  logic [5:0]  cnt;
  logic [71:0] rad;
  logic [37:0] rem;
  logic [39:0] r4;
  logic [39:0] trial;
  logic [39:0] diff;
  logic        ge;

  assign r4    = {rem, rad[71:70]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = r4 >= trial;
  assign diff  = r4 - trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= SQRT_STEPS;
    end else if (busy) begin
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[69:0], 2'b00};
      rem  <= ge ? diff[37:0] : r4[37:0];
      root <= {root[34:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== src/rsn_datapath.sv =====
// Datapath: configuration registers, sphere table, ray and sphere arithmetic,
// result register. Driven by rsn_cmd_t; uses rsn_pkg, rsn_div and rsn_sqrt.
`default_nettype none

module rsn_datapath #(
  parameter int NUM_SPHERES   = 4,
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  rsn_pkg::rsn_item_t   item,
  input  rsn_pkg::rsn_cmd_t    cmd,
  output rsn_pkg::rsn_status_t status,
  input  logic                 result_ready,
  output logic                 result_valid,
  output rsn_pkg::rsn_result_t result
);
  import rsn_pkg::*;

  localparam int SLOT_W = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;

  logic signed [31:0] eye_x, eye_y, eye_z;
  logic [11:0]        divisor;

  logic signed [31:0] tab_cx  [NUM_SPHERES];
  logic signed [31:0] tab_cy  [NUM_SPHERES];
  logic signed [31:0] tab_cz  [NUM_SPHERES];
  logic [30:0]        tab_rad [NUM_SPHERES];

  logic [9:0]         px;
  logic [8:0]         py;
  logic signed [33:0] rv  [3];
  logic [33:0]        mag [3];
  logic [33:0]        mx;
  logic [31:0]        m;
  logic signed [31:0] dv  [3];
  logic signed [32:0] wv  [3];
  logic [30:0]        wrad;
  logic signed [35:0] bval;
  logic signed [71:0] prod;
  logic signed [71:0] acc_b;
  logic signed [71:0] acc_c;
  logic               found;
  logic signed [37:0] best;
  logic [SLOT_W-1:0]  bidx;

  logic               slot_ok;
  logic [SLOT_W-1:0]  wr_slot;
  logic [SLOT_W-1:0]  cmd_slot;
  logic signed [31:0] eye_sel;
  logic [11:0]        div_eff;
  logic               div_start;
  logic [63:0]        div_num;
  logic [31:0]        div_den;
  logic               div_done;
  logic [31:0]        div_q;
  logic               sq_done;
  logic [35:0]        sq_root;
  logic signed [35:0] mul_a, mul_b;
  logic signed [71:0] acc_val;
  logic [33:0]        mag_n [3];
  logic [33:0]        mx_n;
  logic signed [31:0] dq;
  logic signed [37:0] s_ext, nb, t1, t2, tk;
  logic               t_ok;

  assign slot_ok  = int'(item.sphere_slot) < NUM_SPHERES;
  assign wr_slot  = SLOT_W'(item.sphere_slot);
  assign cmd_slot = SLOT_W'(cmd.slot);
  assign div_eff  = (divisor == 12'd0) ? 12'd1 : divisor;

  always_comb begin
    case (cmd.idx)
      2'd0:    eye_sel = eye_x;
      2'd1:    eye_sel = eye_y;
      default: eye_sel = eye_z;
    endcase
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      eye_x   <= EYE_X_RST;
      eye_y   <= EYE_Y_RST;
      eye_z   <= EYE_Z_RST;
      divisor <= DIVISOR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_EYE_X: eye_x   <= cfg_data;
        REG_EYE_Y: eye_y   <= cfg_data;
        REG_EYE_Z: eye_z   <= cfg_data;
        default:   divisor <= cfg_data[11:0];
      endcase
    end
  end

  // sphere table
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_SPHERES; i++) begin
        tab_cx[i]  <= '0;
        tab_cy[i]  <= '0;
        tab_cz[i]  <= '0;
        tab_rad[i] <= '0;
      end
    end else if (cmd.op == OP_ACCEPT && !item.kind && slot_ok) begin
      tab_cx[wr_slot]  <= item.center_x;
      tab_cy[wr_slot]  <= item.center_y;
      tab_cz[wr_slot]  <= item.center_z;
      tab_rad[wr_slot] <= item.radius;
    end
  end

  // shared iterative units
  assign div_start = (cmd.op == OP_DIV_PIX) || (cmd.op == OP_DIV_DIR);

  always_comb begin
    if (cmd.op == OP_DIV_PIX) begin
      div_num = (cmd.idx == 2'd0) ? {38'd0, px, 16'd0} : {39'd0, py, 16'd0};
      div_den = {20'd0, div_eff};
    end else begin
      div_num = {3'd0, mag[cmd.idx][30:0], 30'd0};
      div_den = m;
    end
  end

  rsn_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  rsn_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.op == OP_SQRT),
    .radicand (acc_c),
    .done     (sq_done),
    .root     (sq_root)
  );

  // direction normalization
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_n[i] = rv[i][33] ? 34'(-rv[i]) : 34'(rv[i]);
    end
    mx_n = mag_n[0];
    if (mag_n[1] > mx_n) mx_n = mag_n[1];
    if (mag_n[2] > mx_n) mx_n = mag_n[2];
  end

  // multiplier operands
  always_comb begin
    case (cmd.msel)
      MS_MAG: begin
        mul_a = {5'd0, mag[cmd.idx][30:0]};
        mul_b = {5'd0, mag[cmd.idx][30:0]};
      end
      MS_DW: begin
        mul_a = {{4{dv[cmd.idx][31]}}, dv[cmd.idx]};
        mul_b = {{3{wv[cmd.idx][32]}}, wv[cmd.idx]};
      end
      MS_WW: begin
        mul_a = {{3{wv[cmd.idx][32]}}, wv[cmd.idx]};
        mul_b = {{3{wv[cmd.idx][32]}}, wv[cmd.idx]};
      end
      MS_RR: begin
        mul_a = {5'd0, wrad};
        mul_b = {5'd0, wrad};
      end
      default: begin
        mul_a = bval;
        mul_b = bval;
      end
    endcase
  end

  assign acc_val = cmd.neg ? -prod : prod;
  assign dq      = {1'b0, div_q[30:0]};

  // hit test
  assign s_ext = {2'b00, sq_root};
  assign nb    = -{{2{bval[35]}}, bval};
  assign t1    = nb - s_ext;
  assign t2    = nb + s_ext;
  assign t_ok  = (t1 > 38'sd0) || (t2 > 38'sd0);
  assign tk    = (t1 > 38'sd0) ? t1 : t2;

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        px <= item.pixel_x;
        py <= item.pixel_y;
        rv[2] <= 34'sd0 - {{2{eye_z[31]}}, eye_z};
      end
      OP_STORE_PIX: begin
        rv[cmd.idx] <= $signed({2'b00, div_q}) - {{2{eye_sel[31]}}, eye_sel};
      end
      OP_MAG: begin
        for (int i = 0; i < 3; i++) mag[i] <= mag_n[i];
        mx <= mx_n;
      end
      OP_NORM: begin
        if (|mx[33:31]) begin
          for (int i = 0; i < 3; i++) mag[i] <= {1'b0, mag[i][33:1]};
          mx <= {1'b0, mx[33:1]};
        end else begin
          for (int i = 0; i < 3; i++) mag[i] <= {mag[i][32:0], 1'b0};
          mx <= {mx[32:0], 1'b0};
        end
      end
      OP_MUL: prod <= mul_a * mul_b;
      OP_ACC: begin
        if (cmd.tgt == TGT_B) acc_b <= cmd.clr ? acc_val : acc_b + acc_val;
        else                  acc_c <= cmd.clr ? acc_val : acc_c + acc_val;
      end
      OP_STORE_M: m <= sq_root[31:0];
      OP_STORE_DIR: dv[cmd.idx] <= rv[cmd.idx][33] ? -dq : dq;
      OP_LOAD_W: begin
        wv[0] <= {eye_x[31], eye_x} - {tab_cx[cmd_slot][31], tab_cx[cmd_slot]};
        wv[1] <= {eye_y[31], eye_y} - {tab_cy[cmd_slot][31], tab_cy[cmd_slot]};
        wv[2] <= {eye_z[31], eye_z} - {tab_cz[cmd_slot][31], tab_cz[cmd_slot]};
        wrad  <= tab_rad[cmd_slot];
      end
      OP_FORM_B: bval <= acc_b[65:30];
      default: ;
    endcase
  end

  // nearest hit
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.op == OP_ACCEPT) begin
      found <= 1'b0;
      best  <= '0;
      bidx  <= '0;
    end else if (cmd.op == OP_HIT && t_ok && (!found || tk < best)) begin
      found <= 1'b1;
      best  <= tk;
      bidx  <= cmd_slot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.op == OP_RESULT) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_RESULT) begin
      result.hit          <= found;
      result.sphere_index <= 2'(bidx);
      result.distance     <= (best > 38'sd2147483647) ? 31'h7FFFFFFF : best[30:0];
      result.out_pixel_x  <= px;
      result.out_pixel_y  <= py;
    end
  end

  assign status.cast_ok   = item.kind && (int'(item.pixel_x) < SCREEN_WIDTH)
                            && (int'(item.pixel_y) < SCREEN_HEIGHT);
  assign status.div_done  = div_done;
  assign status.sqrt_done = sq_done;
  assign status.mx_zero   = (mx == 34'd0);
  assign status.norm_ok   = (mx[33:31] == 3'd0) && mx[30];
  assign status.disc_pos  = !acc_c[71] && (|acc_c);
  assign status.out_free  = !result_valid || result_ready;

endmodule

`default_nettype wire

// ===== src/rsn_ctrl.sv =====
// Controller state machine: accepts items and sequences the datapath through each cast.
// Issues rsn_cmd_t and reads rsn_status_t from rsn_pkg.
`default_nettype none

module rsn_ctrl #(
  parameter int NUM_SPHERES = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rsn_pkg::rsn_status_t status,
  output rsn_pkg::rsn_cmd_t    cmd
);
  import rsn_pkg::*;

  localparam int SLOT_W = (NUM_SPHERES > 1) ? $clog2(NUM_SPHERES) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SPHERES - 1);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_PDIV   = 5'd1;
  localparam logic [4:0] S_PWAIT  = 5'd2;
  localparam logic [4:0] S_MAG    = 5'd3;
  localparam logic [4:0] S_NORM   = 5'd4;
  localparam logic [4:0] S_SMUL   = 5'd5;
  localparam logic [4:0] S_SACC   = 5'd6;
  localparam logic [4:0] S_MSQ    = 5'd7;
  localparam logic [4:0] S_MWAIT  = 5'd8;
  localparam logic [4:0] S_DDIV   = 5'd9;
  localparam logic [4:0] S_DWAIT  = 5'd10;
  localparam logic [4:0] S_LOADW  = 5'd11;
  localparam logic [4:0] S_BMUL   = 5'd12;
  localparam logic [4:0] S_BACC   = 5'd13;
  localparam logic [4:0] S_FORMB  = 5'd14;
  localparam logic [4:0] S_CMUL   = 5'd15;
  localparam logic [4:0] S_CACC   = 5'd16;
  localparam logic [4:0] S_DISC   = 5'd17;
  localparam logic [4:0] S_SSQ    = 5'd18;
  localparam logic [4:0] S_SWAIT  = 5'd19;
  localparam logic [4:0] S_NEXT   = 5'd20;
  localparam logic [4:0] S_RESULT = 5'd21;

  logic [4:0]        state, state_next;
  logic [2:0]        step, step_next;
  logic [SLOT_W-1:0] slot, slot_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
      slot  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
      slot  <= slot_next;
    end
  end

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    step_next  = step;
    slot_next  = slot;
    cmd        = '0;
    cmd.op     = OP_IDLE;
    cmd.idx    = step[1:0];
    cmd.slot   = SLOT_CMD_W'(slot);
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.op = OP_ACCEPT;
          if (status.cast_ok) begin
            state_next = S_PDIV;
            step_next  = '0;
          end
        end
      end
      S_PDIV: begin
        cmd.op     = OP_DIV_PIX;
        state_next = S_PWAIT;
      end
      S_PWAIT: begin
        if (status.div_done) begin
          cmd.op = OP_STORE_PIX;
          if (step == 3'd1) begin
            state_next = S_MAG;
          end else begin
            step_next  = step + 3'd1;
            state_next = S_PDIV;
          end
        end
      end
      S_MAG: begin
        cmd.op     = OP_MAG;
        state_next = S_NORM;
      end
      S_NORM: begin
        if (status.mx_zero) begin
          state_next = S_RESULT;
        end else if (status.norm_ok) begin
          step_next  = '0;
          state_next = S_SMUL;
        end else begin
          cmd.op = OP_NORM;
        end
      end
      S_SMUL: begin
        cmd.op     = OP_MUL;
        cmd.msel   = MS_MAG;
        state_next = S_SACC;
      end
      S_SACC: begin
        cmd.op  = OP_ACC;
        cmd.tgt = TGT_C;
        cmd.clr = (step == 3'd0);
        if (step == 3'd2) begin
          state_next = S_MSQ;
        end else begin
          step_next  = step + 3'd1;
          state_next = S_SMUL;
        end
      end
      S_MSQ: begin
        cmd.op     = OP_SQRT;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (status.sqrt_done) begin
          cmd.op     = OP_STORE_M;
          step_next  = '0;
          state_next = S_DDIV;
        end
      end
      S_DDIV: begin
        cmd.op     = OP_DIV_DIR;
        state_next = S_DWAIT;
      end
      S_DWAIT: begin
        if (status.div_done) begin
          cmd.op = OP_STORE_DIR;
          if (step == 3'd2) begin
            slot_next  = '0;
            state_next = S_LOADW;
          end else begin
            step_next  = step + 3'd1;
            state_next = S_DDIV;
          end
        end
      end
      S_LOADW: begin
        cmd.op     = OP_LOAD_W;
        step_next  = '0;
        state_next = S_BMUL;
      end
      S_BMUL: begin
        cmd.op     = OP_MUL;
        cmd.msel   = MS_DW;
        state_next = S_BACC;
      end
      S_BACC: begin
        cmd.op  = OP_ACC;
        cmd.tgt = TGT_B;
        cmd.clr = (step == 3'd0);
        if (step == 3'd2) begin
          state_next = S_FORMB;
        end else begin
          step_next  = step + 3'd1;
          state_next = S_BMUL;
        end
      end
      S_FORMB: begin
        cmd.op     = OP_FORM_B;
        step_next  = '0;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        cmd.op = OP_MUL;
        if (step == 3'd0) begin
          cmd.msel = MS_BB;
        end else if (step == 3'd4) begin
          cmd.msel = MS_RR;
        end else begin
          cmd.msel = MS_WW;
          cmd.idx  = 2'(step - 3'd1);
        end
        state_next = S_CACC;
      end
      S_CACC: begin
        cmd.op  = OP_ACC;
        cmd.tgt = TGT_C;
        cmd.clr = (step == 3'd0);
        cmd.neg = (step != 3'd0) && (step != 3'd4);
        if (step == 3'd4) begin
          state_next = S_DISC;
        end else begin
          step_next  = step + 3'd1;
          state_next = S_CMUL;
        end
      end
      S_DISC: begin
        state_next = status.disc_pos ? S_SSQ : S_NEXT;
      end
      S_SSQ: begin
        cmd.op     = OP_SQRT;
        state_next = S_SWAIT;
      end
      S_SWAIT: begin
        if (status.sqrt_done) begin
          cmd.op     = OP_HIT;
          state_next = S_NEXT;
        end
      end
      S_NEXT: begin
        if (slot == LAST_SLOT) begin
          state_next = S_RESULT;
        end else begin
          slot_next  = slot + 1'b1;
          state_next = S_LOADW;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.op     = OP_RESULT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/rsn_checker.sv =====
// Port-level checks for ray_sphere_nearest_hit, attached by bind.
// Uses rsn_pkg.
`default_nettype none

module rsn_checker #(
  parameter int SCREEN_WIDTH  = 640,
  parameter int SCREEN_HEIGHT = 480
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 item_valid,
  input logic                 item_ready,
  input rsn_pkg::rsn_item_t   item,
  input logic                 result_valid,
  input logic                 result_ready,
  input rsn_pkg::rsn_result_t result
);
  import rsn_pkg::*;

  logic cast_take, load_take;

  assign cast_take = item_valid && item_ready && item.kind
                     && (int'(item.pixel_x) < SCREEN_WIDTH)
                     && (int'(item.pixel_y) < SCREEN_HEIGHT);
  assign load_take = item_valid && item_ready && !item.kind;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    cast_take |=> !item_ready)
    else $error("ready after accepting a cast");

  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    load_take |=> item_ready)
    else $error("load word did not finish in one cycle");

  a_result_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> !$past(item_ready))
    else $error("result appeared without a cast in progress");

  a_hit_dist: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.hit |-> result.distance != 31'd0)
    else $error("hit with zero distance");

endmodule

bind ray_sphere_nearest_hit rsn_checker #(
  .SCREEN_WIDTH  (SCREEN_WIDTH),
  .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_rsn_checker (.*);

`default_nettype wire
